// ===== sv/osbc_pkg.sv =====
// Shared types, constants and divide step for the banded object colorizer.
package osbc_pkg;

   localparam int DIV_STEPS  = 8;
   localparam int BACK_DEPTH = 2 * DIV_STEPS + 1;
   localparam int PROD_STAGE = DIV_STEPS + 1;

   localparam logic REG_MIN = 1'b0;
   localparam logic REG_MAX = 1'b1;

   typedef enum logic [1:0] {
      KIND_BAND,
      KIND_END,
      KIND_BLACK,
      KIND_BELOW
   } kind_type;

   typedef struct packed {
      logic [7:0]       shades;
      logic [2:0][7:0]  end_c;
      logic [2:0][7:0]  start_c;
   } entry_type;

   typedef struct packed {
      kind_type         kind;
      logic [2:0][7:0]  start_c;
      logic [2:0][7:0]  end_c;
      logic [7:0]       m;
      logic [7:0]       range;
      logic [15:0]      dividend;
   } job_type;

   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [2:0][7:0]  start_c;
      logic [2:0][7:0]  end_c;
      logic [7:0]       m;
      logic [7:0]       range;
      logic [15:0]      acc_b;
      logic [2:0][15:0] acc_c;
      logic [2:0]       neg;
   } stage_type;

   // one restoring step: acc = {remainder, dividend bits / quotient bits}
   function automatic logic [15:0] div_step(input logic [15:0] acc, input logic [7:0] d);
      logic [8:0] t;
      logic [8:0] r;
      logic       q;
      t = acc[15:7];
      q = (t >= {1'b0, d});
      r = q ? (t - {1'b0, d}) : t;
      return {r[7:0], acc[6:0], q};
   endfunction

endpackage

// ===== sv/osbc_front.sv =====
// Front end: input transfer, object table, config registers and classification.
module osbc_front import osbc_pkg::*; #(
   parameter int NUM_OBJECTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   output logic        push,
   output job_type     push_job,
   input  logic        queue_ready
);

   localparam int AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;

   entry_type   table_mem [NUM_OBJECTS];
   entry_type   rd_ff;
   logic        f_valid_ff, f_valid_in;
   logic        f_ok_ff;
   logic [7:0]  f_gray_ff;
   logic [7:0]  min_ff, max_ff;
   logic        accept, label_ok;
   logic [7:0]  label, range, g, m;
   entry_type   wr_entry;

   assign label      = req_tdata[7:0];
   assign label_ok   = ({1'b0, label} < 9'(NUM_OBJECTS));
   assign req_tready = !f_valid_ff || queue_ready;
   assign accept     = req_tvalid && req_tready;
   assign push       = f_valid_ff && queue_ready;
   assign f_valid_in = (accept && req_tuser) ? 1'b1 : (push ? 1'b0 : f_valid_ff);

   assign wr_entry.start_c = req_tdata[39:16];
   assign wr_entry.end_c   = req_tdata[63:40];
   assign wr_entry.shades  = req_tdata[71:64];

   always_ff @(posedge clock) begin
      if (accept && !req_tuser && label_ok) begin
         table_mem[label[AW-1:0]] <= wr_entry;
      end
      if (accept && req_tuser) begin
         rd_ff     <= table_mem[label[AW-1:0]];
         f_ok_ff   <= label_ok;
         f_gray_ff <= req_tdata[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         min_ff     <= 8'd0;
         max_ff     <= 8'd255;
      end else begin
         f_valid_ff <= f_valid_in;
         if (csr_we && csr_index == REG_MIN) min_ff <= csr_wdata;
         if (csr_we && csr_index == REG_MAX) max_ff <= csr_wdata;
      end
   end

   assign range = (max_ff > min_ff) ? (max_ff - min_ff) : 8'd0;
   assign g     = f_gray_ff - min_ff;
   assign m     = rd_ff.shades - 8'd1;

   always_comb begin
      push_job.start_c  = rd_ff.start_c;
      push_job.end_c    = rd_ff.end_c;
      push_job.m        = m;
      push_job.range    = range;
      push_job.dividend = {8'd0, g} * {8'd0, m};
      if (!f_ok_ff)                         push_job.kind = KIND_BLACK;
      else if (rd_ff.shades <= 8'd1)        push_job.kind = KIND_END;
      else if (f_gray_ff < min_ff)          push_job.kind = KIND_BELOW;
      else if (range == 8'd0 || g >= range) push_job.kind = KIND_END;
      else                                  push_job.kind = KIND_BAND;
   end

endmodule

// ===== sv/osbc_queue.sv =====
// Four-entry queue between front and back.
module osbc_queue import osbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    queue_ready,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    slot_mem [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff, count_in;

   assign queue_ready = (count_ff != 3'd4);
   assign head_valid  = (count_ff != 3'd0);
   assign head_job    = slot_mem[rd_ptr_ff];
   assign count_in    = count_ff + 3'(push) - 3'(pop);

   always_ff @(posedge clock) begin
      if (push) slot_mem[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/osbc_back.sv =====
// Back end: pipelined band divide, channel products, channel divide, result register.
module osbc_back import osbc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser
);

   stage_type        stg_ff  [1:BACK_DEPTH];
   stage_type        stg_in  [1:BACK_DEPTH];
   stage_type        src     [1:BACK_DEPTH];
   stage_type        head_stg;
   stage_type        last;
   logic             en;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && head_valid;

   always_comb begin
      head_stg         = '0;
      head_stg.valid   = pop;
      head_stg.kind    = head_job.kind;
      head_stg.start_c = head_job.start_c;
      head_stg.end_c   = head_job.end_c;
      head_stg.m       = head_job.m;
      head_stg.range   = head_job.range;
      head_stg.acc_b   = head_job.dividend;
   end

   always_comb begin
      for (int k = 1; k <= BACK_DEPTH; k++) begin
         src[k] = (k == 1) ? head_stg : stg_ff[(k > 1) ? k - 1 : 1];
         stg_in[k] = src[k];
         if (k <= DIV_STEPS) begin
            stg_in[k].acc_b = div_step(src[k].acc_b, src[k].range);
         end else if (k == PROD_STAGE) begin
            for (int c = 0; c < 3; c++) begin
               stg_in[k].neg[c]   = (src[k].end_c[c] < src[k].start_c[c]);
               stg_in[k].acc_c[c] = {8'd0, src[k].acc_b[7:0]} * {8'd0, (stg_in[k].neg[c] ?
                  (src[k].start_c[c] - src[k].end_c[c]) :
                  (src[k].end_c[c] - src[k].start_c[c]))};
            end
         end else begin
            for (int c = 0; c < 3; c++) begin
               stg_in[k].acc_c[c] = div_step(src[k].acc_c[c], src[k].m);
            end
         end
      end
   end

   assign last = stg_ff[BACK_DEPTH];

   always_comb begin
      rsp_data_in = '0;
      rsp_user_in = 1'b0;
      case (last.kind)
         KIND_BAND: begin
            for (int c = 0; c < 3; c++) begin
               rsp_data_in[c*8 +: 8] = last.neg[c] ?
                  (last.start_c[c] - last.acc_c[c][7:0]) :
                  (last.start_c[c] + last.acc_c[c][7:0]);
            end
         end
         KIND_END:   rsp_data_in = last.end_c;
         KIND_BELOW: rsp_user_in = 1'b1;
         default:    rsp_data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= BACK_DEPTH; k++) stg_ff[k] <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         for (int k = 1; k <= BACK_DEPTH; k++) stg_ff[k] <= stg_in[k];
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== sv/object_shade_banded_colorizer.sv =====
// Top level of the banded object colorizer.
// Throughput: one item per cycle while the result output is not stalled; set by the
// fully pipelined band and channel dividers. Entry writes give no result.
// Synchronous active-high reset clears control state and sets min 0 / max 255;
// object table contents stay undefined until written.
module object_shade_banded_colorizer import osbc_pkg::*; #(
   parameter int NUM_OBJECTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // object_label, gray, start_red, start_green, start_blue, end_red, end_green,
   // end_blue, shade_count
   input  logic [71:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red_out, green_out, blue_out
   output logic [23:0] rsp_tdata,
   // below_range
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic    push, queue_ready, pop, head_valid;
   job_type push_job, head_job;

   osbc_front #(.NUM_OBJECTS(NUM_OBJECTS)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .csr_we, .csr_index, .csr_wdata, .push, .push_job, .queue_ready
   );

   osbc_queue u_queue (
      .clock, .reset, .push, .push_job, .queue_ready, .pop, .head_valid, .head_job
   );

   osbc_back u_back (
      .clock, .reset, .head_valid, .head_job, .pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

endmodule

// ===== sv/osbc_checker.sv =====
// Port-level checks for the banded object colorizer.
module osbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_below_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("below range result not black");

endmodule

bind object_shade_banded_colorizer osbc_checker u_osbc_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the banded object colorizer: random entry writes and renders.
`timescale 1ns / 1ps

class color_board;
   logic [7:0] min_v, max_v;
   logic [7:0] s_c [256][3];
   logic [7:0] e_c [256][3];
   logic [7:0] shades [256];
   bit         written [256];
   logic [24:0] pending_colors [$];
   int errors;

   function new();
      min_v = 8'd0;
      max_v = 8'd255;
      errors = 0;
      foreach (written[i]) written[i] = 0;
   endfunction

   function void set_reg(logic idx, logic [7:0] v);
      if (idx == osbc_pkg::REG_MIN) min_v = v;
      else max_v = v;
   endfunction

   function logic [7:0] chan(int s, int e, int b, int m);
      if (e >= s) return 8'(s + (b * (e - s)) / m);
      return 8'(s - (b * (s - e)) / m);
   endfunction

   function void note_item(logic act, logic [71:0] d);
      int lab, g, n, m, rng, b;
      logic [24:0] r;
      lab = d[7:0];
      g = d[15:8];
      if (act == 1'b0) begin
         for (int c = 0; c < 3; c++) begin
            s_c[lab][c] = d[16 + 8 * c +: 8];
            e_c[lab][c] = d[40 + 8 * c +: 8];
         end
         shades[lab] = d[71:64];
         written[lab] = 1;
         return;
      end
      n = shades[lab];
      r = '0;
      if (n <= 1) begin
         r[23:0] = {e_c[lab][2], e_c[lab][1], e_c[lab][0]};
      end else if (g < min_v) begin
         r[24] = 1'b1;
      end else begin
         m = n - 1;
         rng = (max_v > min_v) ? max_v - min_v : 0;
         if (rng == 0) b = m;
         else begin
            b = ((g - min_v) * m) / rng;
            if (b > m) b = m;
         end
         for (int c = 0; c < 3; c++)
            r[8 * c +: 8] = chan(s_c[lab][c], e_c[lab][c], b, m);
      end
      pending_colors = {pending_colors, r};
   endfunction

   function void check_color(logic [23:0] d, logic u);
      logic [24:0] x;
      if (pending_colors.size() == 0) begin
         $display("%0t unexpected result: expected none, actual %h/%b", $time, d, u);
         errors++;
         return;
      end
      x = pending_colors.pop_front();
      if (x[23:0] !== d || x[24] !== u) begin
         $display("%0t mismatch: expected %h/%b, actual %h/%b", $time, x[23:0], x[24], d, u);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0, req_tuser = 0;
   logic [71:0] req_tdata = '0;
   logic        req_tready, rsp_tvalid, rsp_tuser;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 0, csr_index = 0;
   logic [7:0]  csr_wdata = '0;
   int          send_idle = 0, recv_idle = 0;
   int          cycles = 0;
   color_board  board = new();

   object_shade_banded_colorizer dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("object_shade_banded_colorizer verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_color(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic send_item(logic act, logic [71:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(act, d);
   endtask

   task automatic write_reg(logic idx, logic [7:0] v);
      int t;
      t = 0;
      req_tvalid <= 0;
      while (board.pending_colors.size() != 0 && t < 20000) begin
         @(posedge clock);
         t++;
      end
      repeat (25) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.set_reg(idx, v);
   endtask

   function automatic logic [71:0] entry_data(int lab, int n);
      logic [71:0] d;
      d = 72'({$urandom, $urandom, $urandom});
      d[7:0] = 8'(lab);
      d[71:64] = 8'(n);
      return d;
   endfunction

   task automatic render(int lab, int g);
      logic [71:0] d;
      d = 72'({$urandom, $urandom, $urandom});
      d[7:0] = 8'(lab);
      d[15:8] = 8'(g);
      send_item(1, d);
   endtask

   task automatic random_item();
      int lab, n;
      lab = $urandom_range(255);
      if (!board.written[lab] || $urandom_range(9) < 3) begin
         case ($urandom_range(5))
            0: n = 0;
            1: n = 1;
            2: n = $urandom_range(251, 255);
            3: n = $urandom_range(2, 250);
            default: n = $urandom_range(2, 8);
         endcase
         send_item(0, entry_data(lab, n));
      end else begin
         render(lab, $urandom_range(255));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extreme colors and counts, degenerate ranges
      send_item(0, {8'd2, 24'hFFFFFF, 24'h000000, 16'h0000});
      send_item(0, {8'd255, 24'h000000, 24'hFFFFFF, 16'h00FF});
      send_item(0, {8'd1, 24'h123456, 24'hABCDEF, 16'h0001});
      send_item(0, {8'd0, 24'h654321, 24'h0F0F0F, 16'h0002});
      send_item(0, {8'd250, 24'h80FF01, 24'h7F00FE, 16'h0003});
      render(0, 0); render(0, 255); render(255, 0); render(255, 127);
      render(255, 255); render(1, 0); render(2, 77); render(3, 200);
      write_reg(osbc_pkg::REG_MIN, 8'd100);
      write_reg(osbc_pkg::REG_MAX, 8'd50);
      render(0, 99); render(0, 100); render(255, 99); render(255, 150);
      write_reg(osbc_pkg::REG_MAX, 8'd100);
      render(255, 100); render(3, 255);
      write_reg(osbc_pkg::REG_MIN, 8'd0);
      write_reg(osbc_pkg::REG_MAX, 8'd255);
      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph % 3 == 0) ? 38 : (ph % 3 == 1) ? 65 : 0;
         recv_idle = (ph % 3 == 0) ? 65 : (ph % 3 == 1) ? 38 : 0;
         for (int k = 0; k < 170; k++) random_item();
         case (ph)
            0: begin write_reg(osbc_pkg::REG_MIN, 8'd255); write_reg(osbc_pkg::REG_MAX, 8'd0); end
            1: begin write_reg(osbc_pkg::REG_MIN, 8'($urandom_range(255)));
                     write_reg(osbc_pkg::REG_MAX, 8'($urandom_range(255))); end
            2: begin write_reg(osbc_pkg::REG_MIN, 8'd0); write_reg(osbc_pkg::REG_MAX, 8'd1); end
            3: begin write_reg(osbc_pkg::REG_MIN, 8'($urandom_range(0, 60)));
                     write_reg(osbc_pkg::REG_MAX, 8'($urandom_range(180, 255))); end
            default: begin write_reg(osbc_pkg::REG_MIN, 8'd0);
                     write_reg(osbc_pkg::REG_MAX, 8'd255); end
         endcase
      end
      req_tvalid <= 0;
      while (board.pending_colors.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("object_shade_banded_colorizer verification clean");
      else
         $display("object_shade_banded_colorizer verification failed");
      $finish;
   end
endmodule
